@@ src/keyframe_curve_sampler_defines.svh @@
// assertion macros for the keyframe curve sampler
// used by keyframe_curve_sampler.sv, expects signals clock and reset in scope
`ifndef KEYFRAME_CURVE_SAMPLER_DEFINES_SVH
`define KEYFRAME_CURVE_SAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define KCS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyframe curve sampler assertion failed");
`define KCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyframe curve sampler assertion failed");
`else
`define KCS_ASSERT_IMPLY(label, ante, cons)
`define KCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/kcs_pkg.sv @@
// shared widths, codes and the microprogram of the keyframe curve sampler
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package kcs_pkg;

   localparam int MAX_KEYS   = 8;
   localparam int KEY_IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);

   localparam int KEYS_W     = 4;
   localparam int SLOT_W     = 3;
   localparam int TIME_W     = 17;
   localparam int VAL_W      = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TEXT_W     = TIME_W + 2;
   localparam int REM_W      = TEXT_W;
   localparam int PROD_W     = VAL_W + 1 + TIME_W + 1;
   localparam int SUM_W      = PROD_W + 1;
   localparam int DIV_CNT_W  = $clog2(FRAC_BITS);
   localparam int ROUND_HALF = 32768;

   localparam logic [TIME_W-1:0]        ONE_Q16 = TIME_W'(65536);
   localparam logic signed [TEXT_W-1:0] ONE_EXT = TEXT_W'(65536);
   localparam logic signed [VAL_W-1:0]  VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0]  VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]       key_time;
      logic signed [VAL_W-1:0] key_low;
      logic signed [VAL_W-1:0] key_high;
   } key_entry_type;

   // microprogram addresses
   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 5'd0;
   localparam step_type STEP_SCAN     = 5'd1;
   localparam step_type STEP_PLAN     = 5'd2;
   localparam step_type STEP_ST_RD    = 5'd3;
   localparam step_type STEP_ST_LD    = 5'd4;
   localparam step_type STEP_ET_LD    = 5'd5;
   localparam step_type STEP_VS       = 5'd6;
   localparam step_type STEP_VE_MUL   = 5'd7;
   localparam step_type STEP_VE       = 5'd8;
   localparam step_type STEP_DIV      = 5'd9;
   localparam step_type STEP_FRAC     = 5'd10;
   localparam step_type STEP_FMUL     = 5'd11;
   localparam step_type STEP_FLERP    = 5'd12;
   localparam step_type STEP_ONE_RD   = 5'd13;
   localparam step_type STEP_ONE_LD   = 5'd14;
   localparam step_type STEP_ONE_MUL  = 5'd15;
   localparam step_type STEP_ONE_LERP = 5'd16;
   localparam step_type STEP_EMIT     = 5'd17;

   typedef enum logic [1:0] {
      ADDR_ZERO,
      ADDR_SCAN,
      ADDR_START,
      ADDR_END
   } addr_sel_type;

   typedef enum logic [1:0] {
      MLD_NONE,
      MLD_KEY,
      MLD_SEG
   } mul_load_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_SAMPLE,
      COND_SCAN_MORE,
      COND_ONE_KEY,
      COND_DIV_MORE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      mul_load_type mld;
      logic         scan_en;
      logic         plan_en;
      logic         ld_st;
      logic         ld_et;
      logic         mul_en;
      logic         lerp_en;
      logic         save_vs;
      logic         div_init;
      logic         div_step;
      logic         emit_en;
      cond_type     cond;
      step_type     next_t;
      step_type     next_f;
   } ctrl_word_type;

   localparam ctrl_word_type CW_NOP = '{
      addr_sel: ADDR_ZERO, mld: MLD_NONE, scan_en: 1'b0, plan_en: 1'b0,
      ld_st: 1'b0, ld_et: 1'b0, mul_en: 1'b0, lerp_en: 1'b0, save_vs: 1'b0,
      div_init: 1'b0, div_step: 1'b0, emit_en: 1'b0, cond: COND_ALWAYS,
      next_t: STEP_IDLE, next_f: STEP_IDLE
   };

   function automatic logic [TIME_W-1:0] sat_q16(input logic [TIME_W-1:0] x);
      return (x > ONE_Q16) ? ONE_Q16 : x;
   endfunction

   // control store
   function automatic ctrl_word_type ucode_rom(input step_type pc);
      ctrl_word_type w;
      w = CW_NOP;
      case (pc)
         STEP_IDLE: begin
            w.cond   = COND_SAMPLE;
            w.next_t = STEP_SCAN;
            w.next_f = STEP_IDLE;
         end
         STEP_SCAN: begin
            w.addr_sel = ADDR_SCAN;
            w.scan_en  = 1'b1;
            w.cond     = COND_SCAN_MORE;
            w.next_t   = STEP_SCAN;
            w.next_f   = STEP_PLAN;
         end
         STEP_PLAN: begin
            w.plan_en = 1'b1;
            w.cond    = COND_ONE_KEY;
            w.next_t  = STEP_ONE_RD;
            w.next_f  = STEP_ST_RD;
         end
         STEP_ST_RD: begin
            w.addr_sel = ADDR_START;
            w.next_t   = STEP_ST_LD;
            w.next_f   = STEP_ST_LD;
         end
         STEP_ST_LD: begin
            w.addr_sel = ADDR_END;
            w.ld_st    = 1'b1;
            w.mld      = MLD_KEY;
            w.next_t   = STEP_ET_LD;
            w.next_f   = STEP_ET_LD;
         end
         STEP_ET_LD: begin
            w.addr_sel = ADDR_END;
            w.ld_et    = 1'b1;
            w.mul_en   = 1'b1;
            w.next_t   = STEP_VS;
            w.next_f   = STEP_VS;
         end
         STEP_VS: begin
            w.lerp_en = 1'b1;
            w.mld     = MLD_KEY;
            w.next_t  = STEP_VE_MUL;
            w.next_f  = STEP_VE_MUL;
         end
         STEP_VE_MUL: begin
            w.mul_en   = 1'b1;
            w.save_vs  = 1'b1;
            w.div_init = 1'b1;
            w.next_t   = STEP_VE;
            w.next_f   = STEP_VE;
         end
         STEP_VE: begin
            w.lerp_en  = 1'b1;
            w.div_step = 1'b1;
            w.next_t   = STEP_DIV;
            w.next_f   = STEP_DIV;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_MORE;
            w.next_t   = STEP_DIV;
            w.next_f   = STEP_FRAC;
         end
         STEP_FRAC: begin
            w.mld    = MLD_SEG;
            w.next_t = STEP_FMUL;
            w.next_f = STEP_FMUL;
         end
         STEP_FMUL: begin
            w.mul_en = 1'b1;
            w.next_t = STEP_FLERP;
            w.next_f = STEP_FLERP;
         end
         STEP_FLERP: begin
            w.lerp_en = 1'b1;
            w.next_t  = STEP_EMIT;
            w.next_f  = STEP_EMIT;
         end
         STEP_ONE_RD: begin
            w.addr_sel = ADDR_START;
            w.next_t   = STEP_ONE_LD;
            w.next_f   = STEP_ONE_LD;
         end
         STEP_ONE_LD: begin
            w.mld    = MLD_KEY;
            w.next_t = STEP_ONE_MUL;
            w.next_f = STEP_ONE_MUL;
         end
         STEP_ONE_MUL: begin
            w.mul_en = 1'b1;
            w.next_t = STEP_ONE_LERP;
            w.next_f = STEP_ONE_LERP;
         end
         STEP_ONE_LERP: begin
            w.lerp_en = 1'b1;
            w.next_t  = STEP_EMIT;
            w.next_f  = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit_en = 1'b1;
            w.cond    = COND_OUT_FREE;
            w.next_t  = STEP_IDLE;
            w.next_f  = STEP_EMIT;
         end
         default: begin
            w = CW_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/kcs_req_if.sv @@
// request channel of the keyframe curve sampler: valid, ready and request fields
// depends on kcs_pkg
`timescale 1ns / 1ps

interface kcs_req_if import kcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [SLOT_W-1:0]       key_slot;
   logic [TIME_W-1:0]       key_time;
   logic signed [VAL_W-1:0] key_low_value;
   logic signed [VAL_W-1:0] key_high_value;
   logic [TIME_W-1:0]       query_time;
   logic [TIME_W-1:0]       blend_seed;
   logic                    wrap_mode;

   modport source (
      output valid, action, key_slot, key_time, key_low_value, key_high_value,
             query_time, blend_seed, wrap_mode,
      input  ready
   );

   modport sink (
      input  valid, action, key_slot, key_time, key_low_value, key_high_value,
             query_time, blend_seed, wrap_mode,
      output ready
   );
endinterface

@@ src/kcs_rsp_if.sv @@
// response channel of the keyframe curve sampler: valid, ready and curve value
// depends on kcs_pkg
`timescale 1ns / 1ps

interface kcs_rsp_if import kcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] curve_value;

   modport source (
      output valid, curve_value,
      input  ready
   );

   modport sink (
      input  valid, curve_value,
      output ready
   );
endinterface

@@ src/keyframe_curve_sampler.sv @@
// keyframe curve sampler top level: key table, microcoded sequencer and datapath
// depends on kcs_pkg, kcs_req_if, kcs_rsp_if and keyframe_curve_sampler_defines.svh
`timescale 1ns / 1ps
`include "keyframe_curve_sampler_defines.svh"

// The sampler holds up to eight control points of a piecewise-linear curve and
// answers sample requests with one Q16.16 value each; write requests store a
// control point and return nothing. A write request is taken whenever the
// sequencer is idle, even while an earlier sample value is still waiting on
// the response channel. A sample request searches the key table through its
// single read port, one key per cycle, until it finds a key at or after the
// query time or reaches the last key in use; when a single key decides the
// value no division is done, and when two keys are interpolated the 16-step
// restoring divider forms the interpolation fraction. The key table has no
// reset: sampling a key that was never written gives an undefined value.
// keys_in_use may only be written while no sample is in flight.
module keyframe_curve_sampler import kcs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [KEYS_W-1:0] csr_write_data,
   kcs_req_if.sink           req_bus,
   kcs_rsp_if.source         rsp_bus
);

   // control registers
   step_type                step_ff, step_in;
   logic [KEYS_W-1:0]       keys_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [TIME_W-1:0]       q_ff, q_in;
   logic [TIME_W-1:0]       seed_ff, seed_in;
   logic                    wrap_ff, wrap_in;
   logic [KEY_CNT_W-1:0]    n_ff, n_in;
   logic [KEY_IDX_W-1:0]    cnt_ff, cnt_in;
   logic [KEY_CNT_W-1:0]    end_ff, end_in;
   logic [KEY_IDX_W-1:0]    start_idx_ff, start_idx_in;
   logic [KEY_IDX_W-1:0]    end_idx_ff, end_idx_in;
   logic                    st_neg_ff, st_neg_in;
   logic                    et_pos_ff, et_pos_in;
   logic signed [TEXT_W-1:0] st_ff, st_in;
   logic signed [TEXT_W-1:0] et_ff, et_in;
   logic signed [VAL_W-1:0] ma_ff, ma_in;
   logic signed [VAL_W-1:0] mb_ff, mb_in;
   logic [TIME_W-1:0]       mf_ff, mf_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VAL_W-1:0] res_ff, res_in;
   logic signed [VAL_W-1:0] vs_ff, vs_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [REM_W-1:0]        den_ff, den_in;
   logic [FRAC_BITS-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                    one_ff, one_in;
   logic                    zero_ff, zero_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // key table
   key_entry_type           key_mem [MAX_KEYS];
   key_entry_type           rd_ff;
   logic [KEY_IDX_W-1:0]    rd_addr;
   logic [KEY_IDX_W-1:0]    wr_idx;

   ctrl_word_type           cw;
   logic                    req_fire;
   logic                    sample_accept;
   logic                    key_write;
   logic                    out_free;
   logic                    cond_hit;
   logic                    scan_hit;
   logic                    scan_last;
   logic                    plan_one;
   logic [KEY_IDX_W-1:0]    plan_start;
   logic [KEY_IDX_W-1:0]    last_idx;
   logic signed [TEXT_W-1:0] rd_time_ext;
   logic signed [TEXT_W-1:0] q_ext;
   logic signed [TEXT_W-1:0] div_num;
   logic signed [TEXT_W-1:0] div_den;
   logic [REM_W:0]          div_sh;
   logic [REM_W:0]          div_dv;
   logic [REM_W:0]          div_diff;
   logic                    div_ge;
   logic signed [VAL_W:0]   mul_diff;
   logic signed [PROD_W-1:0] mul_prod;
   logic signed [PROD_W-1:0] lerp_rnd;
   logic signed [PROD_W-1:0] lerp_shift;
   logic [SUM_W-1:0]        lerp_sum;
   logic                    lerp_ok;
   logic signed [VAL_W-1:0] lerp_res;
   logic [TIME_W-1:0]       frac_sel;

   assign cw            = ucode_rom(step_ff);
   assign req_bus.ready = (step_ff == STEP_IDLE) && !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign sample_accept = req_fire && (req_bus.action == ACT_SAMPLE);
   assign key_write     = req_fire && (req_bus.action == ACT_WRITE)
                          && (int'(req_bus.key_slot) < MAX_KEYS);
   assign wr_idx        = KEY_IDX_W'(req_bus.key_slot);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.curve_value = rsp_value_ff;

   // key table read address
   always_comb begin
      case (cw.addr_sel)
         ADDR_ZERO:  rd_addr = '0;
         ADDR_SCAN:  rd_addr = cnt_ff + 1'b1;
         ADDR_START: rd_addr = start_idx_ff;
         ADDR_END:   rd_addr = end_idx_ff;
         default:    rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_write) begin
         key_mem[wr_idx] <= '{key_time: sat_q16(req_bus.key_time),
                              key_low:  req_bus.key_low_value,
                              key_high: req_bus.key_high_value};
      end
      rd_ff <= key_mem[rd_addr];
   end

   // search and segment selection
   assign scan_hit  = rd_ff.key_time >= q_ff;
   assign scan_last = (KEY_CNT_W'(cnt_ff) + 1'b1) == n_ff;
   assign last_idx  = KEY_IDX_W'(n_ff - 1'b1);
   assign plan_one  = (n_ff == KEY_CNT_W'(1))
                      || (!wrap_ff && (end_ff == '0 || end_ff == n_ff));

   always_comb begin
      if (n_ff == KEY_CNT_W'(1)) begin
         plan_start = '0;
      end else if (end_ff == '0) begin
         plan_start = wrap_ff ? last_idx : '0;
      end else if (end_ff == n_ff) begin
         plan_start = last_idx;
      end else begin
         plan_start = KEY_IDX_W'(end_ff - 1'b1);
      end
   end

   // fraction divider
   assign rd_time_ext = $signed({{(TEXT_W-TIME_W){1'b0}}, rd_ff.key_time});
   assign q_ext       = $signed({{(TEXT_W-TIME_W){1'b0}}, q_ff});
   assign div_num     = q_ext - st_ff;
   assign div_den     = et_ff - st_ff;
   assign div_sh      = {rem_ff, 1'b0};
   assign div_dv      = {1'b0, den_ff};
   assign div_ge      = div_sh >= div_dv;
   assign div_diff    = div_sh - div_dv;

   assign frac_sel = one_ff  ? ONE_Q16 :
                     zero_ff ? '0      : {1'b0, quo_ff};

   // shared lerp unit: multiply, then round and saturate
   assign mul_diff   = {mb_ff[VAL_W-1], mb_ff} - {ma_ff[VAL_W-1], ma_ff};
   assign mul_prod   = mul_diff * $signed({1'b0, mf_ff});
   assign lerp_rnd   = prod_ff + PROD_W'(ROUND_HALF);
   assign lerp_shift = lerp_rnd >>> FRAC_BITS;
   assign lerp_sum   = {{(SUM_W-VAL_W){ma_ff[VAL_W-1]}}, ma_ff}
                       + {lerp_shift[PROD_W-1], lerp_shift};
   assign lerp_ok    = (&lerp_sum[SUM_W-1:VAL_W-1]) || !(|lerp_sum[SUM_W-1:VAL_W-1]);
   assign lerp_res   = lerp_ok ? $signed(lerp_sum[VAL_W-1:0])
                               : (lerp_sum[SUM_W-1] ? VAL_MIN : VAL_MAX);

   // sequencer condition
   always_comb begin
      case (cw.cond)
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_SAMPLE:    cond_hit = sample_accept;
         COND_SCAN_MORE: cond_hit = !scan_hit && !scan_last;
         COND_ONE_KEY:   cond_hit = plan_one;
         COND_DIV_MORE:  cond_hit = div_cnt_ff != DIV_CNT_W'(FRAC_BITS - 1);
         COND_OUT_FREE:  cond_hit = out_free;
         default:        cond_hit = 1'b1;
      endcase
   end

   always_comb begin
      step_in      = cond_hit ? cw.next_t : cw.next_f;
      q_in         = q_ff;
      seed_in      = seed_ff;
      wrap_in      = wrap_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      start_idx_in = start_idx_ff;
      end_idx_in   = end_idx_ff;
      st_neg_in    = st_neg_ff;
      et_pos_in    = et_pos_ff;
      st_in        = st_ff;
      et_in        = et_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mf_in        = mf_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      vs_in        = vs_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      one_in       = one_ff;
      zero_in      = zero_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff;

      if (sample_accept) begin
         q_in    = sat_q16(req_bus.query_time);
         seed_in = sat_q16(req_bus.blend_seed);
         wrap_in = req_bus.wrap_mode;
         cnt_in  = '0;
         if (keys_ff == '0) begin
            n_in = KEY_CNT_W'(1);
         end else if (int'(keys_ff) > MAX_KEYS) begin
            n_in = KEY_CNT_W'(MAX_KEYS);
         end else begin
            n_in = KEY_CNT_W'(keys_ff);
         end
      end

      if (cw.scan_en) begin
         if (scan_hit) begin
            end_in = KEY_CNT_W'(cnt_ff);
         end else if (scan_last) begin
            end_in = n_ff;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      if (cw.plan_en) begin
         start_idx_in = plan_start;
         end_idx_in   = (end_ff == n_ff) ? '0 : KEY_IDX_W'(end_ff);
         st_neg_in    = wrap_ff && (end_ff == '0);
         et_pos_in    = wrap_ff && (end_ff == n_ff);
      end

      if (cw.ld_st) begin
         st_in = st_neg_ff ? rd_time_ext - ONE_EXT : rd_time_ext;
      end
      if (cw.ld_et) begin
         et_in = et_pos_ff ? rd_time_ext + ONE_EXT : rd_time_ext;
      end

      case (cw.mld)
         MLD_KEY: begin
            ma_in = rd_ff.key_low;
            mb_in = rd_ff.key_high;
            mf_in = seed_ff;
         end
         MLD_SEG: begin
            ma_in = vs_ff;
            mb_in = res_ff;
            mf_in = frac_sel;
         end
         default: begin
            ma_in = ma_ff;
         end
      endcase

      if (cw.mul_en) begin
         prod_in = mul_prod;
      end
      if (cw.lerp_en) begin
         res_in = lerp_res;
      end
      if (cw.save_vs) begin
         vs_in = res_ff;
      end

      // empty span gives the end key, a span not yet reached gives the start key
      if (cw.div_init) begin
         rem_in     = REM_W'(div_num);
         den_in     = REM_W'(div_den);
         quo_in     = '0;
         div_cnt_in = '0;
         one_in     = div_den[TEXT_W-1] || (div_den == '0)
                      || (!div_num[TEXT_W-1] && (div_num >= div_den));
         zero_in    = div_num[TEXT_W-1] || (div_num == '0);
      end
      if (cw.div_step) begin
         rem_in     = div_ge ? REM_W'(div_diff) : REM_W'(div_sh);
         quo_in     = {quo_ff[FRAC_BITS-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cw.emit_en && out_free) begin
         rsp_value_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         keys_ff      <= KEYS_W'(1);
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            keys_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      seed_ff      <= seed_in;
      wrap_ff      <= wrap_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      end_ff       <= end_in;
      start_idx_ff <= start_idx_in;
      end_idx_ff   <= end_idx_in;
      st_neg_ff    <= st_neg_in;
      et_pos_ff    <= et_pos_in;
      st_ff        <= st_in;
      et_ff        <= et_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      mf_ff        <= mf_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      vs_ff        <= vs_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      one_ff       <= one_in;
      zero_ff      <= zero_in;
      rsp_value_ff <= rsp_value_in;
   end

   // checks
   `KCS_ASSERT_NEXT(a_sample_starts_scan, sample_accept, step_ff == STEP_SCAN)
   `KCS_ASSERT_IMPLY(a_scan_in_range, step_ff == STEP_SCAN, KEY_CNT_W'(cnt_ff) < n_ff)
   `KCS_ASSERT_IMPLY(a_plan_end_in_range, step_ff == STEP_PLAN, end_ff <= n_ff)
   `KCS_ASSERT_IMPLY(a_div_started, step_ff == STEP_DIV, div_cnt_ff != '0)
   `KCS_ASSERT_NEXT(a_emit_delivers, (step_ff == STEP_EMIT) && out_free, rsp_valid_ff && (step_ff == STEP_IDLE))

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for keyframe_curve_sampler: directed and random requests
// with a fixed-point curve predictor; depends on kcs_pkg, kcs_req_if, kcs_rsp_if
`timescale 1ns / 1ps

module testbench import kcs_pkg::*; ();

   typedef struct {
      logic                    action;
      logic [SLOT_W-1:0]       key_slot;
      logic [TIME_W-1:0]       key_time;
      logic signed [VAL_W-1:0] key_low_value;
      logic signed [VAL_W-1:0] key_high_value;
      logic [TIME_W-1:0]       query_time;
      logic [TIME_W-1:0]       blend_seed;
      logic                    wrap_mode;
   } curve_request_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [KEYS_W-1:0] csr_write_data;

   kcs_req_if req_bus ();
   kcs_rsp_if rsp_bus ();

   keyframe_curve_sampler dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the key table and key count
   logic [TIME_W-1:0]       key_time_q [MAX_KEYS];
   logic signed [VAL_W-1:0] key_low_q  [MAX_KEYS];
   logic signed [VAL_W-1:0] key_high_q [MAX_KEYS];
   logic [KEYS_W-1:0]       key_count = KEYS_W'(1);

   logic signed [VAL_W-1:0] expected_curve_q [$];
   logic signed [VAL_W-1:0] wanted_curve;
   int fail_count = 0;
   int send_idle_pct = 15;
   int recv_idle_pct = 56;

   function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W-1:0] x);
      return (x > ONE_Q16) ? ONE_Q16 : x;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint f);
      longint r;
      r = a + (((b - a) * f + 64'sd32768) >>> 16);
      if (r > longint'(VAL_MAX)) r = longint'(VAL_MAX);
      if (r < longint'(VAL_MIN)) r = longint'(VAL_MIN);
      return r;
   endfunction

   function automatic longint key_level(input int k, input longint seed);
      return blend(longint'(key_low_q[k]), longint'(key_high_q[k]), seed);
   endfunction

   function automatic logic signed [VAL_W-1:0] predict_curve(input curve_request_type r);
      longint q, seed, st, et, num, den, frac;
      int n, lo, hi;
      q = longint'(clamp_time(r.query_time));
      seed = longint'(clamp_time(r.blend_seed));
      n = int'(key_count);
      if (n < 1) n = 1;
      if (n > MAX_KEYS) n = MAX_KEYS;
      if (n == 1) return VAL_W'(key_level(0, seed));
      hi = 0;
      while (hi < n && longint'(key_time_q[hi]) < q) hi++;
      if (!r.wrap_mode) begin
         if (hi == 0) return VAL_W'(key_level(0, seed));
         if (hi == n) return VAL_W'(key_level(n - 1, seed));
         lo = hi - 1;
         st = longint'(key_time_q[lo]);
         et = longint'(key_time_q[hi]);
      end else if (hi == 0) begin
         lo = n - 1;
         st = longint'(key_time_q[lo]) - 65536;
         et = longint'(key_time_q[0]);
      end else if (hi == n) begin
         lo = n - 1;
         hi = 0;
         st = longint'(key_time_q[lo]);
         et = longint'(key_time_q[0]) + 65536;
      end else begin
         lo = hi - 1;
         st = longint'(key_time_q[lo]);
         et = longint'(key_time_q[hi]);
      end
      num = q - st;
      den = et - st;
      if (den <= 0) begin
         frac = 65536;
      end else if (num <= 0) begin
         frac = 0;
      end else begin
         frac = (num * 65536) / den;
         if (frac > 65536) frac = 65536;
      end
      return VAL_W'(blend(key_level(lo, seed), key_level(hi, seed), frac));
   endfunction

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      case ($urandom_range(0, 9))
         0: return TIME_W'($urandom_range(0, 131071));
         1: return '0;
         2: return ONE_Q16;
         default: return TIME_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic curve_request_type random_request();
      curve_request_type r;
      r.action = ($urandom_range(0, 4) == 0) ? ACT_WRITE : ACT_SAMPLE;
      r.key_slot = SLOT_W'($urandom_range(0, 7));
      r.key_time = random_time();
      r.key_low_value = random_value();
      r.key_high_value = random_value();
      if ($urandom_range(0, 6) == 0) r.query_time = key_time_q[$urandom_range(0, MAX_KEYS - 1)];
      else r.query_time = random_time();
      r.blend_seed = random_time();
      r.wrap_mode = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic curve_request_type key_write(input int slot, input int t,
                                                   input logic signed [VAL_W-1:0] lo,
                                                   input logic signed [VAL_W-1:0] hi);
      curve_request_type r;
      r = random_request();
      r.action = ACT_WRITE;
      r.key_slot = SLOT_W'(slot);
      r.key_time = TIME_W'(t);
      r.key_low_value = lo;
      r.key_high_value = hi;
      return r;
   endfunction

   function automatic curve_request_type curve_sample(input int q, input int seed,
                                                      input logic wrap);
      curve_request_type r;
      r = random_request();
      r.action = ACT_SAMPLE;
      r.query_time = TIME_W'(q);
      r.blend_seed = TIME_W'(seed);
      r.wrap_mode = wrap;
      return r;
   endfunction

   task automatic send_request(input curve_request_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= r.action;
      req_bus.key_slot       <= r.key_slot;
      req_bus.key_time       <= r.key_time;
      req_bus.key_low_value  <= r.key_low_value;
      req_bus.key_high_value <= r.key_high_value;
      req_bus.query_time     <= r.query_time;
      req_bus.blend_seed     <= r.blend_seed;
      req_bus.wrap_mode      <= r.wrap_mode;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (r.action == ACT_SAMPLE) begin
         expected_curve_q.push_back(predict_curve(r));
      end else begin
         key_time_q[r.key_slot] = clamp_time(r.key_time);
         key_low_q[r.key_slot]  = r.key_low_value;
         key_high_q[r.key_slot] = r.key_high_value;
      end
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (expected_curve_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_key_count(input int count);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_write_data   <= KEYS_W'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_count = KEYS_W'(count);
      @(posedge clock);
   endtask

   task automatic reload_key_table();
      int t;
      for (int i = 0; i < MAX_KEYS; i++) begin
         t = i * 8192 + $urandom_range(0, 8192);
         if ($urandom_range(0, 7) == 0) t = $urandom_range(0, 131071);
         send_request(key_write(i, t, random_value(), random_value()));
      end
   endtask

   task automatic test_key_table_load();
      send_request(key_write(0, 4096, VAL_MIN, VAL_MAX));
      send_request(key_write(1, 16384, VAL_MAX, VAL_MIN));
      for (int i = 2; i < MAX_KEYS - 1; i++) begin
         send_request(key_write(i, i * 8192, random_value(), random_value()));
      end
      send_request(key_write(MAX_KEYS - 1, 131071, '1, '0));
   endtask

   task automatic test_single_key();
      send_request(curve_sample(0, 0, 1'b0));
      send_request(curve_sample(65536, 65536, 1'b1));
      send_request(curve_sample(131071, 131071, 1'b0));
   endtask

   task automatic test_clamp_ends();
      set_key_count(4);
      send_request(curve_sample(0, 32768, 1'b0));
      send_request(curve_sample(65536, 12345, 1'b0));
      send_request(curve_sample(20000, 40000, 1'b0));
      send_request(curve_sample(16384, 65536, 1'b0));
   endtask

   task automatic test_wrap_ends();
      send_request(curve_sample(0, 32768, 1'b1));
      send_request(curve_sample(65536, 1, 1'b1));
      send_request(curve_sample(28000, 65535, 1'b1));
   endtask

   task automatic test_key_count_limits();
      set_key_count(0);
      send_request(curve_sample(40000, 20000, 1'b1));
      set_key_count(15);
      send_request(curve_sample(131071, 50000, 1'b1));
      send_request(curve_sample(60000, 0, 1'b0));
   endtask

   // first key at 0.0 and last at 1.0 leave a zero-length wrap span at time 0
   task automatic test_empty_span();
      set_key_count(MAX_KEYS);
      send_request(key_write(0, 0, 32'sd65536, -32'sd65536));
      send_request(curve_sample(0, 30000, 1'b1));
      send_request(curve_sample(0, 30000, 1'b0));
   endtask

   task automatic run_random_phase(input int count, input int send_pct,
                                   input int recv_pct, input int items);
      set_key_count(count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      reload_key_table();
      repeat (items) send_request(random_request());
   endtask

   task automatic test_random_traffic();
      run_random_phase(MAX_KEYS, 15, 56, 315);
      run_random_phase(2, 15, 56, 315);
      run_random_phase(15, 56, 15, 315);
      run_random_phase(1, 56, 15, 315);
      run_random_phase($urandom_range(3, 7), 0, 0, 315);
      run_random_phase(0, 0, 0, 315);
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_curve_q.size() == 0) begin
            $error("curve_value: expected none, actual %0d", rsp_bus.curve_value);
            fail_count++;
         end else begin
            wanted_curve = expected_curve_q.pop_front();
            if (rsp_bus.curve_value !== wanted_curve) begin
               $error("curve_value: expected %0d, actual %0d", wanted_curve,
                      rsp_bus.curve_value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < MAX_KEYS; i++) begin
         key_time_q[i] = '0;
         key_low_q[i]  = '0;
         key_high_q[i] = '0;
      end
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_write_data         <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= ACT_WRITE;
      req_bus.key_slot       <= '0;
      req_bus.key_time       <= '0;
      req_bus.key_low_value  <= '0;
      req_bus.key_high_value <= '0;
      req_bus.query_time     <= '0;
      req_bus.blend_seed     <= '0;
      req_bus.wrap_mode      <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_key_table_load();
      test_single_key();
      test_clamp_ends();
      test_wrap_ends();
      test_key_count_limits();
      test_empty_span();
      test_random_traffic();
      drain_pipeline();
      if (fail_count == 0) begin
         $display("keyframe_curve_sampler regression: pass");
      end else begin
         $display("keyframe_curve_sampler regression: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("keyframe_curve_sampler regression: fail");
      $finish;
   end

endmodule
